// File: design/bfdc_pkg.sv
// ----------------------------------------------------------------------------
// bfdc_pkg: shared types and constants for the box/frustum/distance culler
// Word formats, configuration register indexes and the distance-class tables.
// ----------------------------------------------------------------------------
`default_nettype none

package bfdc_pkg;

    // Field and register widths
    localparam int FIELD_W    = 20;   // signed Q15.4 coordinate fields
    localparam int COEF_W     = 14;   // signed Q1.12 plane normal terms
    localparam int PLANE_W    = 62;
    localparam int CAMERA_W   = 60;
    localparam int RANGE_W    = 9;    // unsigned Q1.8 range factor
    localparam int CLASS_W    = 2;
    localparam int MASK_W     = 6;
    localparam int MAX_PLANES = 6;
    localparam int D_SHIFT    = 12;   // d is Q.4, products are Q.16

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = PLANE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE      = 3'd7;

    localparam logic [RANGE_W-1:0] RANGE_RESET = 9'd256;

    // Default parameter values
    localparam int PLANE_COUNT_DEF = 6;
    localparam int COORD_WIDTH_DEF = 20;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Distance-class tables, whole units
    localparam int DIST_W = 9;
    localparam logic [DIST_W-1:0] DIST_MIN [4] = '{9'd100, 9'd70, 9'd40, 9'd128};
    localparam logic [DIST_W-1:0] DIST_MAX [4] = '{9'd400, 9'd200, 9'd70, 9'd400};

    // Distance arithmetic widths
    localparam int SQ_W  = 2 * FIELD_W;        // one squared axis delta
    localparam int D2_W  = SQ_W + 2;           // sum of three squares
    localparam int N_W   = 18;                 // min*256 + factor*span
    localparam int NN_W  = 2 * N_W;
    localparam int CMP_W = SQ_W + 8;           // d2 * 256 below 2^40 case

    // Input word
    typedef struct packed {
        logic signed [FIELD_W-1:0] corner_x;
        logic signed [FIELD_W-1:0] corner_y;
        logic signed [FIELD_W-1:0] corner_z;
        logic signed [FIELD_W-1:0] object_x;
        logic signed [FIELD_W-1:0] object_y;
        logic signed [FIELD_W-1:0] object_z;
        logic [CLASS_W-1:0]        distance_class;
        logic                      last_corner;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic              visible;
        logic              too_far;
        logic [MASK_W-1:0] common_outside_mask;
    } t_out_word;

endpackage

`default_nettype wire

// File: design/box_frustum_distance_cull_unit.sv
// ----------------------------------------------------------------------------
// box_frustum_distance_cull_unit: bounding-box frustum and view-distance cull
// Tests box corners against the frustum planes, ANDs the outside masks and
// on the last corner of a box issues a visibility word.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_ready / i_in_word) takes one corner word
//    per handshake. Words with last_corner = 0 only update the outside AND.
//  - Output channel (o_out_valid / i_out_ready / o_out_word) gives one word
//    per box, on its last corner: visible, too_far and the common mask.
//  - Config port writes registers 0..5 (planes), 6 (camera), 7 (range factor);
//    write only while the block is idle.
//  - Each corner occupies the plane engine for a load step, one plane per
//    cycle through three multipliers, and a final sign step. A last corner
//    adds the squared-distance test: squares, sum of squares, then decide.
//  - The input register and a two-word queue let the front keep accepting
//    while the engine or a stalled receiver holds the back.
//  - When the receiver stalls, one result waits in the output register and
//    the engine holds the next one until it drains.
//  - Reset clears the planes and camera, sets the range factor to 1.0 and
//    the outside AND to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module box_frustum_distance_cull_unit #(
    parameter int PLANE_COUNT = bfdc_pkg::PLANE_COUNT_DEF,
    parameter int COORD_WIDTH = bfdc_pkg::COORD_WIDTH_DEF,
    parameter int QUEUE_DEPTH = bfdc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  bfdc_pkg::t_in_word             i_in_word,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output bfdc_pkg::t_out_word                  o_out_word,
    input  wire                                  i_cfg_we,
    input  wire  [bfdc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [bfdc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int ENTRY_W = 3 * COORD_WIDTH + 3 * bfdc_pkg::FIELD_W + 4;

    logic [PLANE_COUNT-1:0][bfdc_pkg::PLANE_W-1:0] r_plane;
    logic [bfdc_pkg::CAMERA_W-1:0]                 r_camera;
    logic [bfdc_pkg::RANGE_W-1:0]                  r_range;

    logic                 push_valid, push_ready;
    logic [ENTRY_W-1:0]   push_data;
    logic                 pop_valid, pop_ready;
    logic [ENTRY_W-1:0]   pop_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane  <= '0;
            r_camera <= '0;
            r_range  <= bfdc_pkg::RANGE_RESET;
        end else if (i_cfg_we) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                if (i_cfg_idx == bfdc_pkg::CFG_PLANE_BASE + bfdc_pkg::CFG_IDX_W'(p)) begin
                    r_plane[p] <= i_cfg_data[bfdc_pkg::PLANE_W-1:0];
                end
            end
            if (i_cfg_idx == bfdc_pkg::CFG_CAMERA) begin
                r_camera <= i_cfg_data[bfdc_pkg::CAMERA_W-1:0];
            end
            if (i_cfg_idx == bfdc_pkg::CFG_RANGE) begin
                r_range <= i_cfg_data[bfdc_pkg::RANGE_W-1:0];
            end
        end
    end

    bfdc_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_camera     (r_camera),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    bfdc_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    bfdc_back #(
        .PLANE_COUNT (PLANE_COUNT),
        .COORD_WIDTH (COORD_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .i_planes    (r_plane),
        .i_range     (r_range),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

// File: design/bfdc_front.sv
// ----------------------------------------------------------------------------
// bfdc_front: input stage
// Accepts corner words, narrows coordinates to COORD_WIDTH, forms the
// camera-to-object axis deltas and packs a task entry for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdc_front #(
    parameter int COORD_WIDTH = bfdc_pkg::COORD_WIDTH_DEF,
    parameter int ENTRY_W     = 3 * COORD_WIDTH + 3 * bfdc_pkg::FIELD_W + 4
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire  bfdc_pkg::t_in_word              i_in_word,
    input  wire  [bfdc_pkg::CAMERA_W-1:0]         i_camera,
    output logic                                  o_push_valid,
    input  wire                                   i_push_ready,
    output logic [ENTRY_W-1:0]                    o_push_data
);

    localparam int FW = bfdc_pkg::FIELD_W;
    localparam int MW = (COORD_WIDTH > FW) ? COORD_WIDTH : FW;

    // Low COORD_WIDTH bits of a field, two's complement
    function automatic logic signed [COORD_WIDTH-1:0] f_coord(input logic [FW-1:0] v);
        logic signed [MW-1:0] t;
        t = $signed(MW'(v) << (MW - COORD_WIDTH));
        f_coord = COORD_WIDTH'(t >>> (MW - COORD_WIDTH));
    endfunction

    // |camera - object| on one axis; big when it reaches 2^20
    function automatic logic [FW:0] f_delta(input logic [FW-1:0] cam,
                                            input logic signed [COORD_WIDTH-1:0] obj);
        logic signed [MW:0] diff;
        logic [MW:0]        mag;
        diff = (MW+1)'($signed(cam)) - (MW+1)'(obj);
        mag  = diff[MW] ? (MW+1)'(-diff) : (MW+1)'(diff);
        f_delta = {|mag[MW:FW], mag[FW-1:0]};
    endfunction

    logic                      r_valid;
    logic [ENTRY_W-1:0]        r_entry;
    logic [ENTRY_W-1:0]        n_entry;
    logic [FW:0]               dlt_x, dlt_y, dlt_z;
    logic                      accept;

    assign o_in_ready   = !r_valid || i_push_ready;
    assign accept       = i_in_valid && o_in_ready;
    assign o_push_valid = r_valid;
    assign o_push_data  = r_entry;

    // Classify: axis deltas and range flag
    always_comb begin
        dlt_x = f_delta(i_camera[FW-1:0],      f_coord(i_in_word.object_x));
        dlt_y = f_delta(i_camera[2*FW-1:FW],   f_coord(i_in_word.object_y));
        dlt_z = f_delta(i_camera[3*FW-1:2*FW], f_coord(i_in_word.object_z));
        n_entry = {i_in_word.last_corner,
                   i_in_word.distance_class,
                   dlt_x[FW] | dlt_y[FW] | dlt_z[FW],
                   dlt_z[FW-1:0], dlt_y[FW-1:0], dlt_x[FW-1:0],
                   f_coord(i_in_word.corner_z),
                   f_coord(i_in_word.corner_y),
                   f_coord(i_in_word.corner_x)};
    end

    // Holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

endmodule

`default_nettype wire

// File: design/bfdc_queue.sv
// ----------------------------------------------------------------------------
// bfdc_queue: small FIFO between front and back
// Circular buffer with a fill count; push and pop in the same cycle allowed.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdc_queue #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = bfdc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push_valid,
    output logic                o_push_ready,
    input  wire  [DATA_W-1:0]   i_push_data,
    output logic                o_pop_valid,
    input  wire                 i_pop_ready,
    output logic [DATA_W-1:0]   o_pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [CW-1:0]     r_cnt;
    logic              push, pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// File: design/bfdc_back.sv
// ----------------------------------------------------------------------------
// bfdc_back: plane and distance engine
// Walks the planes one per cycle (three products, then sum and sign), keeps
// the running outside AND, and on the last corner runs the distance test.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdc_back #(
    parameter int PLANE_COUNT = bfdc_pkg::PLANE_COUNT_DEF,
    parameter int COORD_WIDTH = bfdc_pkg::COORD_WIDTH_DEF,
    parameter int ENTRY_W     = 3 * COORD_WIDTH + 3 * bfdc_pkg::FIELD_W + 4
) (
    input  wire                                              i_clk,
    input  wire                                              i_rst_n,
    input  wire                                              i_pop_valid,
    output logic                                             o_pop_ready,
    input  wire  [ENTRY_W-1:0]                               i_pop_data,
    input  wire  [PLANE_COUNT-1:0][bfdc_pkg::PLANE_W-1:0]    i_planes,
    input  wire  [bfdc_pkg::RANGE_W-1:0]                     i_range,
    output logic                                             o_out_valid,
    input  wire                                              i_out_ready,
    output bfdc_pkg::t_out_word                              o_out_word
);

    localparam int FW   = bfdc_pkg::FIELD_W;
    localparam int KW   = bfdc_pkg::COEF_W;
    localparam int PW   = COORD_WIDTH + KW;
    localparam int DSW  = FW + bfdc_pkg::D_SHIFT;
    localparam int SW   = ((PW > DSW) ? PW : DSW) + 2;
    localparam int PI_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
    localparam int SQ_W = bfdc_pkg::SQ_W;
    localparam int D2_W = bfdc_pkg::D2_W;
    localparam int N_W  = bfdc_pkg::N_W;
    localparam int NN_W = bfdc_pkg::NN_W;
    localparam int CP_W = bfdc_pkg::CMP_W;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PLANE  = 6'b000010,
        ST_DRAIN  = 6'b000100,
        ST_SQUARE = 6'b001000,
        ST_ACCUM  = 6'b010000,
        ST_DECIDE = 6'b100000
    } t_state;

    // Queue entry fields
    logic                                e_last, e_big;
    logic [bfdc_pkg::CLASS_W-1:0]        e_cls;
    logic [FW-1:0]                       e_adx, e_ady, e_adz;
    logic signed [COORD_WIDTH-1:0]       e_cx, e_cy, e_cz;

    assign {e_last, e_cls, e_big, e_adz, e_ady, e_adx, e_cz, e_cy, e_cx} = i_pop_data;

    t_state                              r_state, n_state;
    logic                                r_last, r_big;
    logic [bfdc_pkg::CLASS_W-1:0]        r_cls;
    logic [FW-1:0]                       r_adx, r_ady, r_adz;
    logic signed [COORD_WIDTH-1:0]       r_cx, r_cy, r_cz;
    logic [PI_W-1:0]                     r_pidx;
    logic                                r_pvalid;
    logic [PI_W-1:0]                     r_pvidx;
    logic signed [PW-1:0]                r_pa, r_pb, r_pc;
    logic signed [FW-1:0]                r_pd;
    logic [PLANE_COUNT-1:0]              r_cmask, n_cmask;
    logic [PLANE_COUNT-1:0]              r_and;
    logic [SQ_W-1:0]                     r_sqx, r_sqy, r_sqz;
    logic [N_W-1:0]                      r_n;
    logic [D2_W-1:0]                     r_d2;
    logic [NN_W-1:0]                     r_nn;
    logic                                r_out_valid;
    bfdc_pkg::t_out_word                 r_out_word;

    logic [bfdc_pkg::PLANE_W-1:0]        plane;
    logic signed [SW-1:0]                sum;
    logic [bfdc_pkg::DIST_W-1:0]         dmin, dspan;
    logic                                out_free;
    logic                                too_far;

    assign o_pop_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign out_free    = !r_out_valid || i_out_ready;
    assign plane       = i_planes[r_pidx];

    // Sign of the previous plane's dot product
    always_comb begin
        sum = SW'(r_pa) + SW'(r_pb) + SW'(r_pc) + (SW'(r_pd) <<< bfdc_pkg::D_SHIFT);
        n_cmask = r_cmask;
        if (r_pvalid && sum[SW-1]) begin
            n_cmask[r_pvidx] = 1'b1;
        end
    end

    // Class limits
    always_comb begin
        dmin  = bfdc_pkg::DIST_MIN[r_cls];
        dspan = bfdc_pkg::DIST_MAX[r_cls] - bfdc_pkg::DIST_MIN[r_cls];
    end

    // Strict test: d2*256 > n*n, anything at or past 2^40 is too far
    always_comb begin
        too_far = r_big || (|r_d2[D2_W-1:SQ_W]) ||
                  ({r_d2[SQ_W-1:0], 8'd0} > CP_W'(r_nn));
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_pop_valid) n_state = ST_PLANE;
            ST_PLANE:  if (r_pidx == PI_W'(PLANE_COUNT - 1)) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = r_last ? ST_SQUARE : ST_IDLE;
            ST_SQUARE: n_state = ST_ACCUM;
            ST_ACCUM:  n_state = ST_DECIDE;
            ST_DECIDE: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pvalid    <= 1'b0;
            r_and       <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_PLANE) begin
                r_pvalid <= 1'b1;
            end else begin
                r_pvalid <= 1'b0;
            end
            if (r_state == ST_DRAIN) begin
                r_and <= r_and & n_cmask;
            end
            if (r_state == ST_DECIDE && out_free) begin
                r_and       <= '1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        // load task
        if (r_state == ST_IDLE && i_pop_valid) begin
            r_last  <= e_last;
            r_big   <= e_big;
            r_cls   <= e_cls;
            r_adx   <= e_adx;
            r_ady   <= e_ady;
            r_adz   <= e_adz;
            r_cx    <= e_cx;
            r_cy    <= e_cy;
            r_cz    <= e_cz;
            r_pidx  <= '0;
            r_cmask <= '0;
        end
        // plane products, one plane per cycle
        if (r_state == ST_PLANE) begin
            r_pa    <= PW'($signed(plane[KW-1:0]))      * PW'(r_cx);
            r_pb    <= PW'($signed(plane[2*KW-1:KW]))   * PW'(r_cy);
            r_pc    <= PW'($signed(plane[3*KW-1:2*KW])) * PW'(r_cz);
            r_pd    <= $signed(plane[3*KW+FW-1:3*KW]);
            r_pvidx <= r_pidx;
            r_pidx  <= r_pidx + 1'b1;
        end
        if (r_state == ST_PLANE || r_state == ST_DRAIN) begin
            r_cmask <= n_cmask;
        end
        // distance: squares and limit
        if (r_state == ST_SQUARE) begin
            r_sqx <= SQ_W'(r_adx) * SQ_W'(r_adx);
            r_sqy <= SQ_W'(r_ady) * SQ_W'(r_ady);
            r_sqz <= SQ_W'(r_adz) * SQ_W'(r_adz);
            r_n   <= (N_W'(dmin) << 8) + N_W'(i_range) * N_W'(dspan);
        end
        if (r_state == ST_ACCUM) begin
            r_d2 <= D2_W'(r_sqx) + D2_W'(r_sqy) + D2_W'(r_sqz);
            r_nn <= NN_W'(r_n) * NN_W'(r_n);
        end
        // result word
        if (r_state == ST_DECIDE && out_free) begin
            r_out_word.visible             <= !too_far && (r_and == '0);
            r_out_word.too_far             <= too_far;
            r_out_word.common_outside_mask <= bfdc_pkg::MASK_W'(r_and);
        end
    end

endmodule

`default_nettype wire
